/* rtl/line_editor_with_timeout_defines.svh */
// ----------------------------------------------------------------------------
// Line editor assertion macros
// Concurrent assertion wrappers for the line editor; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef LINE_EDITOR_WITH_TIMEOUT_DEFINES_SVH
`define LINE_EDITOR_WITH_TIMEOUT_DEFINES_SVH

`ifndef SYNTH
`define LEWT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("line editor assertion failed");
`define LEWT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line editor assertion failed");
`else
`define LEWT_ASSERT(label, clk, rst_n, prop)
`define LEWT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/lewt_pkg.sv */
// ----------------------------------------------------------------------------
// Line editor package
// Codes, result record and fixed limits of the line editor.
// ----------------------------------------------------------------------------
package lewt_pkg;

  localparam int MAX_LINE = 256;
  localparam logic [8:0] LINE_CAP = (MAX_LINE > 256) ? 9'd256 : 9'(MAX_LINE);

  localparam logic [8:0]  MAX_LENGTH_RST    = 9'd256;
  localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd1000000;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_EOF = 8'hFF;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  typedef enum logic [0:0] {
    REG_MAX_LENGTH    = 1'b0,
    REG_TIMEOUT_TICKS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    GRP_ECHO    = 2'd0,
    GRP_EOL     = 2'd1,
    GRP_BS      = 2'd2,
    GRP_TIMEOUT = 2'd3
  } grp_kind_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_char;
    logic       line_done;
    logic       line_ok;
    logic [7:0] line_length;
    logic       last;
  } res_t;

endpackage

/* rtl/line_editor_with_timeout.sv */
// ----------------------------------------------------------------------------
// Line editor with timeout
// Console line input engine with echo, backspace editing and tick timeout.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_action (start, byte, tick) and
// in_rx_byte. A transfer takes place when in_valid is high and in_stall low.
// Result channel: out_valid/out_stall with echo, buffer store and line end
// fields; out_last marks the final result of one input item.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index selects
// max_length (0) or timeout_ticks (1), cfg_data holds the value.
// Each item updates the line state in the cycle of its transfer and loads
// its result group (none to three results) into a group register; results
// then leave through the output register one per cycle unless the receiver
// stalls. The first result passes the group register, then the output
// register, before out_valid rises. Items with at most one result are taken
// one per cycle while nothing stalls; backspace (three results) and line end
// (two) hold the group register and in_stall until their last result loads.
// On a receiver stall the output register holds, and a loaded group register
// holds behind it with in_stall high. Reset clears the line state, empties
// both registers and returns the config registers to 256 and 1000000.
// ----------------------------------------------------------------------------
`include "line_editor_with_timeout_defines.svh"

module line_editor_with_timeout (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_echo_valid,
  output logic [7:0]  out_echo_char,
  output logic        out_store_valid,
  output logic [7:0]  out_store_index,
  output logic [7:0]  out_store_char,
  output logic        out_line_done,
  output logic        out_line_ok,
  output logic [7:0]  out_line_length,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [8:0]  max_length_r;
  logic [31:0] timeout_r;
  logic [7:0]  position_r, position_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic        active_r, active_nxt;

  logic                grp_valid_r;
  lewt_pkg::grp_kind_t grp_kind_r, grp_kind_nxt;
  logic [1:0]          grp_sub_r;
  logic [7:0]          grp_char_r, grp_char_nxt;
  logic [7:0]          grp_idx_r, grp_idx_nxt;
  logic [7:0]          grp_len_r, grp_len_nxt;
  logic                grp_done_r, grp_done_nxt;
  logic                grp_load;

  logic            out_valid_r;
  lewt_pkg::res_t  out_r, res;

  logic        in_xfer, out_load;
  logic [8:0]  size, char_limit;
  logic [7:0]  pos_inc;
  logic        store_end;
  logic [31:0] tick_nxt;
  logic        tick_end;
  logic        is_eol;
  lewt_pkg::action_t act;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= lewt_pkg::MAX_LENGTH_RST;
      timeout_r    <= lewt_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (lewt_pkg::cfg_reg_t'(cfg_index))
        lewt_pkg::REG_MAX_LENGTH:    max_length_r <= cfg_data[8:0];
        lewt_pkg::REG_TIMEOUT_TICKS: timeout_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    size = max_length_r;
    if (size > lewt_pkg::LINE_CAP) size = lewt_pkg::LINE_CAP;
    if (size < 9'd2) size = 9'd2;
    char_limit = size - 9'd1;
  end

  assign pos_inc   = position_r + 8'd1;
  assign store_end = {1'b0, pos_inc} >= char_limit;
  assign tick_nxt  = (elapsed_r == 32'hFFFF_FFFF) ? elapsed_r : elapsed_r + 32'd1;
  assign tick_end  = tick_nxt >= timeout_r;
  assign is_eol    = (in_rx_byte == lewt_pkg::CH_CR) || (in_rx_byte == lewt_pkg::CH_LF) ||
                     (in_rx_byte == lewt_pkg::CH_EOF);
  assign act       = lewt_pkg::action_t'(in_action);

  always_comb begin
    position_nxt = position_r;
    elapsed_nxt  = elapsed_r;
    active_nxt   = active_r;
    grp_load     = 1'b0;
    grp_kind_nxt = lewt_pkg::GRP_ECHO;
    grp_char_nxt = in_rx_byte;
    grp_idx_nxt  = position_r;
    grp_len_nxt  = position_r;
    grp_done_nxt = 1'b0;
    case (act)
      lewt_pkg::ACT_START: begin
        active_nxt   = 1'b1;
        position_nxt = 8'd0;
        elapsed_nxt  = 32'd0;
      end
      lewt_pkg::ACT_BYTE: begin
        if (active_r) begin
          if (is_eol) begin
            active_nxt   = 1'b0;
            grp_load     = 1'b1;
            grp_kind_nxt = lewt_pkg::GRP_EOL;
          end else if (in_rx_byte == lewt_pkg::CH_BS) begin
            if (position_r != 8'd0) begin
              position_nxt = position_r - 8'd1;
              grp_load     = 1'b1;
              grp_kind_nxt = lewt_pkg::GRP_BS;
            end
          end else begin
            position_nxt = pos_inc;
            grp_load     = 1'b1;
            grp_kind_nxt = lewt_pkg::GRP_ECHO;
            grp_len_nxt  = pos_inc;
            grp_done_nxt = store_end;
            if (store_end) active_nxt = 1'b0;
          end
        end
      end
      lewt_pkg::ACT_TICK: begin
        if (active_r) begin
          elapsed_nxt = tick_nxt;
          if (tick_end) begin
            active_nxt   = 1'b0;
            grp_load     = 1'b1;
            grp_kind_nxt = lewt_pkg::GRP_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res = '0;
    case (grp_kind_r)
      lewt_pkg::GRP_ECHO: begin
        res.echo_valid  = 1'b1;
        res.echo_char   = grp_char_r;
        res.store_valid = 1'b1;
        res.store_index = grp_idx_r;
        res.store_char  = grp_char_r;
        res.line_done   = grp_done_r;
        res.line_ok     = grp_done_r;
        res.line_length = grp_done_r ? grp_len_r : 8'd0;
        res.last        = 1'b1;
      end
      lewt_pkg::GRP_EOL: begin
        res.echo_valid = 1'b1;
        if (grp_sub_r == 2'd0) begin
          res.echo_char = lewt_pkg::CH_CR;
        end else begin
          res.echo_char   = lewt_pkg::CH_LF;
          res.line_done   = 1'b1;
          res.line_ok     = 1'b1;
          res.line_length = grp_len_r;
          res.last        = 1'b1;
        end
      end
      lewt_pkg::GRP_BS: begin
        res.echo_valid = 1'b1;
        res.echo_char  = (grp_sub_r == 2'd1) ? lewt_pkg::CH_SP : lewt_pkg::CH_BS;
        res.last       = (grp_sub_r == 2'd2);
      end
      lewt_pkg::GRP_TIMEOUT: begin
        res.line_done   = 1'b1;
        res.line_length = grp_len_r;
        res.last        = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_load = grp_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = grp_valid_r && !(out_load && res.last);
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= 8'd0;
      elapsed_r  <= 32'd0;
      active_r   <= 1'b0;
    end else if (in_xfer) begin
      position_r <= position_nxt;
      elapsed_r  <= elapsed_nxt;
      active_r   <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      grp_sub_r   <= 2'd0;
    end else if (in_xfer && grp_load) begin
      grp_valid_r <= 1'b1;
      grp_sub_r   <= 2'd0;
    end else if (out_load && res.last) begin
      grp_valid_r <= 1'b0;
    end else if (out_load) begin
      grp_sub_r <= grp_sub_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && grp_load) begin
      grp_kind_r <= grp_kind_nxt;
      grp_char_r <= grp_char_nxt;
      grp_idx_r  <= grp_idx_nxt;
      grp_len_r  <= grp_len_nxt;
      grp_done_r <= grp_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_echo_valid  = out_r.echo_valid;
  assign out_echo_char   = out_r.echo_char;
  assign out_store_valid = out_r.store_valid;
  assign out_store_index = out_r.store_index;
  assign out_store_char  = out_r.store_char;
  assign out_line_done   = out_r.line_done;
  assign out_line_ok     = out_r.line_ok;
  assign out_line_length = out_r.line_length;
  assign out_last        = out_r.last;

  `LEWT_ASSERT_IMPL(a_done_is_last, clk, rst_n, out_valid_r && out_r.line_done, out_r.last)
  `LEWT_ASSERT_IMPL(a_no_echo_timeout, clk, rst_n, out_valid_r && !out_r.echo_valid,
                    out_r.line_done && !out_r.line_ok)
  `LEWT_ASSERT_IMPL(a_store_echoes, clk, rst_n, out_valid_r && out_r.store_valid,
                    out_r.echo_valid && (out_r.echo_char == out_r.store_char))
  `LEWT_ASSERT_IMPL(a_pos_bound, clk, rst_n, active_r, position_r != 8'hFF)

endmodule
